@@ rtl/pffl_pkg.sv @@
package pffl_pkg;

  localparam int PAGES_DEF      = 128;
  localparam int PAGE_BYTES_DEF = 4096;

  localparam int CMD_W   = 2;
  localparam int COUNT_W = 8;
  localparam int HEAD_W  = 8;
  localparam int FIRST_W = 7;
  localparam int BASE_W  = 19;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_INIT  = 2'd0;
  localparam cmd_t CMD_ALLOC = 2'd1;
  localparam cmd_t CMD_FREE  = 2'd2;
  localparam cmd_t CMD_NONE  = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC,
    ST_FREE,
    ST_PUSH
  } state_t;

endpackage

@@ rtl/pffl_in_if.sv @@
interface pffl_in_if;
  import pffl_pkg::*;

  logic                 valid;
  logic                 ready;
  cmd_t                 command;
  logic [COUNT_W-1:0]   page_count;
  logic [HEAD_W-1:0]    list_head;

  modport source(output valid, output command, output page_count, output list_head,
                 input ready);
  modport sink(input valid, input command, input page_count, input list_head,
               output ready);
endinterface

@@ rtl/pffl_out_if.sv @@
interface pffl_out_if;
  import pffl_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 granted;
  logic [FIRST_W-1:0]   first_page;
  logic [BASE_W-1:0]    base_address;

  modport source(output valid, output granted, output first_page, output base_address,
                 input ready);
  modport sink(input valid, input granted, input first_page, input base_address,
               output ready);
endinterface

@@ rtl/pffl_link_ram.sv @@
module pffl_link_ram #(
  parameter int DEPTH = pffl_pkg::PAGES_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

@@ rtl/page_frame_free_list_allocator_unit.sv @@
// channel | dir | handshake           | word
// in_chan | in  | valid/ready         | command, page_count, list_head
// out_chan| out | valid/ready         | granted, first_page, base_address
//
// One command at a time; the link table is a registered-read RAM, one link read per cycle.
// The result follows a walk over the n frames of an allocate or an L-frame freed chain,
// or a rewrite of the table on initialize; a zero count or empty list skips the walk.
// After reset the same table rewrite runs before the first word is accepted.
// The next word is taken in the cycle after the result word is loaded; a stalled result
// holds the block in its push cycle until the output register frees up.
module page_frame_free_list_allocator_unit #(
  parameter int PAGES      = pffl_pkg::PAGES_DEF,
  parameter int PAGE_BYTES = pffl_pkg::PAGE_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pffl_in_if.sink    in_chan,
  pffl_out_if.source out_chan
);
  import pffl_pkg::*;

  localparam int IW     = $clog2(PAGES);
  localparam int LW     = $clog2(PAGES + 1);
  localparam int PB_W   = $clog2(PAGE_BYTES + 1);
  localparam int PROD_W = FIRST_W + PB_W;
  localparam logic [LW-1:0] NULL_LINK = LW'(PAGES);
  localparam logic [IW-1:0] LAST_IDX  = IW'(PAGES - 1);

  state_t             state_r, state_nxt;
  logic [IW-1:0]      cur_r, cur_nxt;
  logic [IW-1:0]      first_r, first_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [LW-1:0]      steps_r, steps_nxt;
  logic [LW-1:0]      head_r, head_nxt;
  logic [IW-1:0]      idx_r, idx_nxt;
  logic               init_cmd_r, init_cmd_nxt;
  logic               res_granted_r, res_granted_nxt;
  logic [IW-1:0]      res_first_r, res_first_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_granted_r, out_granted_nxt;
  logic [FIRST_W-1:0] out_first_r, out_first_nxt;
  logic [BASE_W-1:0]  out_base_r, out_base_nxt;

  logic               mem_we;
  logic [IW-1:0]      mem_wa;
  logic [LW-1:0]      mem_wd;
  logic [IW-1:0]      mem_ra;
  logic [LW-1:0]      rd_q;

  logic               in_fire;
  logic               out_free;
  logic               head_is_frame;
  logic               rd_is_frame;
  logic               list_is_frame;
  logic               alloc_fail;
  logic [FIRST_W-1:0] res_first7;
  logic [PROD_W-1:0]  res_prod;

  pffl_link_ram #(
    .DEPTH(PAGES),
    .AW   (IW),
    .DW   (LW)
  ) u_link_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_wa),
    .wdata(mem_wd),
    .raddr(mem_ra),
    .rdata(rd_q)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;
  assign out_free      = !out_valid_r || out_chan.ready;

  assign head_is_frame = (head_r < NULL_LINK);
  assign rd_is_frame   = (rd_q < NULL_LINK);
  assign list_is_frame = (32'(in_chan.list_head) < 32'(PAGES));
  assign alloc_fail    = (in_chan.page_count == '0) || !head_is_frame;

  assign res_first7 = FIRST_W'(res_first_r);
  assign res_prod   = PROD_W'(res_first7) * PROD_W'(PAGE_BYTES);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (idx_r == LAST_IDX) begin
          state_nxt = init_cmd_r ? ST_PUSH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_chan.command)
            CMD_INIT:  state_nxt = ST_CLEAR;
            CMD_ALLOC: state_nxt = alloc_fail ? ST_PUSH : ST_ALLOC;
            CMD_FREE:  state_nxt = list_is_frame ? ST_FREE : ST_PUSH;
            default:   state_nxt = ST_PUSH;
          endcase
        end
      end
      ST_ALLOC: begin
        if (rem_r == '0 || !rd_is_frame) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_FREE: begin
        if (!(steps_r < NULL_LINK && rd_is_frame)) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and table access
  always_comb begin
    cur_nxt         = cur_r;
    first_nxt       = first_r;
    rem_nxt         = rem_r;
    steps_nxt       = steps_r;
    head_nxt        = head_r;
    idx_nxt         = idx_r;
    init_cmd_nxt    = init_cmd_r;
    res_granted_nxt = res_granted_r;
    res_first_nxt   = res_first_r;
    out_valid_nxt   = out_valid_r && !out_chan.ready;
    out_granted_nxt = out_granted_r;
    out_first_nxt   = out_first_r;
    out_base_nxt    = out_base_r;
    mem_we          = 1'b0;
    mem_wa          = cur_r;
    mem_wd          = NULL_LINK;
    mem_ra          = cur_r;

    case (state_r)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_wa   = idx_r;
        mem_wd   = LW'(idx_r) + LW'(1);
        head_nxt = '0;
        idx_nxt  = idx_r + IW'(1);
        if (idx_r == LAST_IDX) begin
          idx_nxt         = '0;
          init_cmd_nxt    = 1'b0;
          res_granted_nxt = 1'b1;
          res_first_nxt   = '0;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (in_chan.command)
            CMD_INIT: begin
              idx_nxt      = '0;
              init_cmd_nxt = 1'b1;
            end
            CMD_ALLOC: begin
              res_granted_nxt = 1'b0;
              res_first_nxt   = '0;
              cur_nxt         = head_r[IW-1:0];
              first_nxt       = head_r[IW-1:0];
              rem_nxt         = in_chan.page_count - COUNT_W'(1);
              mem_ra          = head_r[IW-1:0];
            end
            CMD_FREE: begin
              res_granted_nxt = 1'b1;
              res_first_nxt   = '0;
              cur_nxt         = IW'(in_chan.list_head);
              first_nxt       = IW'(in_chan.list_head);
              steps_nxt       = '0;
              mem_ra          = IW'(in_chan.list_head);
            end
            default: begin
              res_granted_nxt = 1'b0;
              res_first_nxt   = '0;
            end
          endcase
        end
      end
      ST_ALLOC: begin
        // rd_q is the link out of cur_r
        if (rem_r == '0) begin
          head_nxt        = rd_q;
          mem_we          = 1'b1;
          mem_wa          = cur_r;
          mem_wd          = NULL_LINK;
          res_granted_nxt = 1'b1;
          res_first_nxt   = first_r;
        end else if (rd_is_frame) begin
          cur_nxt = rd_q[IW-1:0];
          rem_nxt = rem_r - COUNT_W'(1);
          mem_ra  = rd_q[IW-1:0];
        end
      end
      ST_FREE: begin
        if (steps_r < NULL_LINK && rd_is_frame) begin
          cur_nxt   = rd_q[IW-1:0];
          steps_nxt = steps_r + LW'(1);
          mem_ra    = rd_q[IW-1:0];
        end else begin
          // splice the chain tail in front of the current head
          mem_we   = 1'b1;
          mem_wa   = cur_r;
          mem_wd   = head_r;
          head_nxt = LW'(first_r);
        end
      end
      ST_PUSH: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = res_granted_r;
          out_first_nxt   = res_first7;
          out_base_nxt    = BASE_W'(res_prod);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      head_r      <= '0;
      idx_r       <= '0;
      init_cmd_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      idx_r       <= idx_nxt;
      init_cmd_r  <= init_cmd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r         <= cur_nxt;
    first_r       <= first_nxt;
    rem_r         <= rem_nxt;
    steps_r       <= steps_nxt;
    res_granted_r <= res_granted_nxt;
    res_first_r   <= res_first_nxt;
    out_granted_r <= out_granted_nxt;
    out_first_r   <= out_first_nxt;
    out_base_r    <= out_base_nxt;
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.granted      = out_granted_r;
  assign out_chan.first_page   = out_first_r;
  assign out_chan.base_address = out_base_r;

  a_head_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= NULL_LINK)
    else $error("free head out of range");

  a_alloc_cuts_null: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ALLOC && mem_we) |-> (mem_wd == NULL_LINK))
    else $error("allocate must terminate the cut run");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_PUSH) |-> !mem_we)
    else $error("link table written outside a command");

  a_push_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not loaded");
endmodule
